FILE: sv/mtsp_pkg.sv
// Shared types and constants of the matmul tile size planner.
// Holds the configuration layout, the controller states and the
// command and status structs between controller and datapath.
`default_nettype none

package mtsp_pkg;

    localparam int CW_W       = 11;
    localparam int EB_W       = 4;
    localparam int SPK_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_RADIX_BITS = 4;
    localparam int HALF_SHIFT     = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARRAY_WIDTH      = 2'd0,
        CFG_ELEMENT_BYTES    = 2'd1,
        CFG_SCRATCHPAD_KIB   = 2'd2,
        CFG_TRANSPOSE_ENABLE = 2'd3
    } t_cfg_idx;

    localparam logic [CW_W-1:0]  RST_ARRAY_WIDTH      = 11'd128;
    localparam logic [EB_W-1:0]  RST_ELEMENT_BYTES    = 4'd2;
    localparam logic [SPK_W-1:0] RST_SCRATCHPAD_KIB   = 16'd1024;
    localparam logic             RST_TRANSPOSE_ENABLE = 1'b1;

    typedef struct packed {
        logic [CW_W-1:0]  array_width;
        logic [EB_W-1:0]  element_bytes;
        logic [SPK_W-1:0] scratchpad_kib;
        logic             transpose_enable;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RND_LOAD,
        ST_RND_STEP,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_SCALE,
        ST_CHECK,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        PAIR_AB,
        PAIR_BC,
        PAIR_CA
    } t_pair;

    typedef struct packed {
        logic  load;
        logic  div_load;
        logic  div_step;
        logic  div_last;
        logic  next_idx;
        logic  mul_en;
        t_pair mul_pair;
        logic  acc_clr;
        logic  acc_en;
        logic  scale;
        logic  halve;
        logic  no_fit;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic over;
        logic blocked;
        logic idx_last;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/mtsp_in_if.sv
// Input channel of the tile size planner: one matmul job per item.
// Stand-alone; carries valid, ready and the job fields.
`default_nettype none

interface mtsp_in_if #(
    parameter int DIM_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] m_rows;
    logic [DIM_BITS-1:0] k_depth;
    logic [DIM_BITS-1:0] n_cols;
    logic                row_override_on;
    logic [DIM_BITS-1:0] row_override_count;

    modport source (
        output valid, m_rows, k_depth, n_cols, row_override_on, row_override_count,
        input  ready
    );

    modport sink (
        input  valid, m_rows, k_depth, n_cols, row_override_on, row_override_count,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/mtsp_out_if.sv
// Output channel of the tile size planner: one tile plan per item.
// Stand-alone; carries valid, ready and the plan fields.
`default_nettype none

interface mtsp_out_if #(
    parameter int DIM_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] tile_first;
    logic [DIM_BITS-1:0] tile_middle;
    logic [DIM_BITS-1:0] tile_last;
    logic [DIM_BITS:0]   count_first;
    logic [DIM_BITS:0]   count_middle;
    logic [DIM_BITS:0]   count_last;
    logic                transposed;
    logic                k_major_order;
    logic                fits;

    modport source (
        output valid, tile_first, tile_middle, tile_last,
               count_first, count_middle, count_last,
               transposed, k_major_order, fits,
        input  ready
    );

    modport sink (
        input  valid, tile_first, tile_middle, tile_last,
               count_first, count_middle, count_last,
               transposed, k_major_order, fits,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/mtsp_ctrl.sv
// Controller of the tile size planner: sequences rounding, footprint
// multiplies, the fit check and halving. Uses mtsp_pkg.
`default_nettype none

module mtsp_ctrl
    import mtsp_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam int DIV_CYC = (DIM_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam logic [CYC_W-1:0] STEP_LAST = CYC_W'(DIV_CYC - 1);

    t_state           r_state, n_state;
    logic [CYC_W-1:0] r_step, n_step;
    logic             r_init, n_init;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_init  = r_init;
        o_cmd   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_init     = 1'b1;
                    n_state    = ST_RND_LOAD;
                end
            end
            ST_RND_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = ST_RND_STEP;
            end
            ST_RND_STEP: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    o_cmd.div_last = 1'b1;
                    if (r_init && !i_sts.idx_last) begin
                        o_cmd.next_idx = 1'b1;
                        n_state        = ST_RND_LOAD;
                    end else begin
                        n_init  = 1'b0;
                        n_state = ST_MUL0;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MUL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_pair = PAIR_AB;
                o_cmd.acc_clr  = 1'b1;
                n_state        = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_pair = PAIR_BC;
                o_cmd.acc_en   = 1'b1;
                n_state        = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_pair = PAIR_CA;
                o_cmd.acc_en   = 1'b1;
                n_state        = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                if (!i_sts.over) begin
                    n_state = ST_FINISH;
                end else if (i_sts.blocked) begin
                    o_cmd.no_fit = 1'b1;
                    n_state      = ST_FINISH;
                end else begin
                    o_cmd.halve = 1'b1;
                    n_state     = ST_RND_LOAD;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: sv/mtsp_dp.sv
// Datapath of the tile size planner: tile sizes and counts, radix-16
// remainder unit for rounding, shared multiplier, output register. Uses mtsp_pkg.
`default_nettype none

module mtsp_dp
    import mtsp_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire t_cfg                i_cfg,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [DIM_BITS-1:0] i_m_rows,
    input  wire logic [DIM_BITS-1:0] i_k_depth,
    input  wire logic [DIM_BITS-1:0] i_n_cols,
    input  wire logic                i_row_override_on,
    input  wire logic [DIM_BITS-1:0] i_row_override_count,
    output logic [DIM_BITS-1:0]      o_tile_first,
    output logic [DIM_BITS-1:0]      o_tile_middle,
    output logic [DIM_BITS-1:0]      o_tile_last,
    output logic [DIM_BITS:0]        o_count_first,
    output logic [DIM_BITS:0]        o_count_middle,
    output logic [DIM_BITS:0]        o_count_last,
    output logic                     o_transposed,
    output logic                     o_k_major_order,
    output logic                     o_fits
);

    localparam int DIV_CYC = (DIM_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int PAD_W   = DIV_CYC * DIV_RADIX_BITS;
    localparam int RW      = ((DIM_BITS > CW_W) ? DIM_BITS : CW_W) + 1;
    localparam int PROD_W  = 2 * RW;
    localparam int SUM_W   = PROD_W + 2;
    localparam int FOOT_W  = SUM_W + EB_W;
    localparam int HALF_W  = SPK_W + HALF_SHIFT;

    logic [DIM_BITS-1:0] r_sz  [3];
    logic [DIM_BITS:0]   r_cnt [3];
    logic [RW-1:0]       r_rnd [3];
    logic [1:0]          r_idx;
    logic                r_tr;
    logic                r_fits;
    logic [PAD_W-1:0]    r_dvd;
    logic [CW_W-1:0]     r_rem;
    logic [PROD_W-1:0]   r_prod;
    logic [SUM_W-1:0]    r_sum;
    logic [FOOT_W-1:0]   r_foot;

    logic [CW_W-1:0]     w_eff;
    logic [CW_W-1:0]     rem_nxt;
    logic [RW-1:0]       rnd_v;
    logic [RW-1:0]       op_x, op_y;
    logic [1:0]          sel;
    logic [DIM_BITS-1:0] m_eff;
    logic [HALF_W-1:0]   half_v;

    assign w_eff = (i_cfg.array_width == '0) ? CW_W'(1) : i_cfg.array_width;

    always_comb begin
        logic [CW_W-1:0] rem_v;
        logic [CW_W:0]   t_v;
        rem_v = r_rem;
        for (int j = 0; j < DIV_RADIX_BITS; j++) begin
            t_v = {rem_v, r_dvd[PAD_W-1-j]};
            if (t_v >= {1'b0, w_eff}) begin
                rem_v = CW_W'(t_v - {1'b0, w_eff});
            end else begin
                rem_v = t_v[CW_W-1:0];
            end
        end
        rem_nxt = rem_v;
    end

    assign rnd_v = RW'(r_sz[r_idx])
                 + ((rem_nxt != '0) ? RW'(w_eff - rem_nxt) : RW'(0));

    always_comb begin
        case (i_cmd.mul_pair)
            PAIR_BC: begin
                op_x = r_rnd[1];
                op_y = r_rnd[2];
            end
            PAIR_CA: begin
                op_x = r_rnd[2];
                op_y = r_rnd[0];
            end
            default: begin
                op_x = r_rnd[0];
                op_y = r_rnd[1];
            end
        endcase
    end

    always_comb begin
        sel = 2'd0;
        if (r_sz[1] > r_sz[0]) begin
            sel = 2'd1;
        end
        if (r_sz[2] > r_sz[sel]) begin
            sel = 2'd2;
        end
    end

    assign m_eff  = i_row_override_on ? i_row_override_count : i_m_rows;
    assign half_v = {i_cfg.scratchpad_kib, {HALF_SHIFT{1'b0}}};

    assign o_sts.over     = (r_foot > FOOT_W'(half_v));
    assign o_sts.blocked  = (r_sz[sel] <= DIM_BITS'(1));
    assign o_sts.idx_last = (r_idx == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sz[0]  <= m_eff;
            r_sz[1]  <= i_k_depth;
            r_sz[2]  <= i_n_cols;
            for (int i = 0; i < 3; i++) begin
                r_cnt[i] <= (DIM_BITS + 1)'(1);
            end
            r_idx    <= 2'd0;
            r_fits   <= 1'b1;
            r_tr     <= i_cfg.transpose_enable && (i_n_cols > m_eff);
        end
        if (i_cmd.div_load) begin
            r_dvd <= PAD_W'(r_sz[r_idx]);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= r_dvd << DIV_RADIX_BITS;
            r_rem <= rem_nxt;
        end
        if (i_cmd.div_last) begin
            r_rnd[r_idx] <= rnd_v;
        end
        if (i_cmd.next_idx) begin
            r_idx <= r_idx + 2'd1;
        end
        if (i_cmd.mul_en) begin
            r_prod <= op_x * op_y;
        end
        if (i_cmd.acc_clr) begin
            r_sum <= '0;
        end else if (i_cmd.acc_en) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
        if (i_cmd.scale) begin
            r_foot <= FOOT_W'(r_sum) * FOOT_W'(i_cfg.element_bytes);
        end
        if (i_cmd.halve) begin
            r_idx      <= sel;
            r_cnt[sel] <= r_cnt[sel] << 1;
            r_sz[sel]  <= (r_sz[sel] >> 1) + DIM_BITS'(r_sz[sel][0]);
        end
        if (i_cmd.no_fit) begin
            r_fits <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DIM_BITS:0] c_first, c_last, c_big;
        c_first = r_tr ? r_cnt[2] : r_cnt[0];
        c_last  = r_tr ? r_cnt[0] : r_cnt[2];
        c_big   = (c_first > c_last) ? c_first : c_last;
        if (i_cmd.out_load) begin
            o_tile_first    <= r_tr ? r_sz[2] : r_sz[0];
            o_tile_middle   <= r_sz[1];
            o_tile_last     <= r_tr ? r_sz[0] : r_sz[2];
            o_count_first   <= c_first;
            o_count_middle  <= r_cnt[1];
            o_count_last    <= c_last;
            o_transposed    <= r_tr;
            o_k_major_order <= ({1'b0, r_cnt[1]} > {c_big, 1'b0});
            o_fits          <= r_fits;
        end
    end

endmodule

`default_nettype wire

FILE: sv/matmul_tile_size_planner.sv
// Matmul tile size planner: one job in, one tile plan out.
// Each job: round all three sizes up to a multiple of the array width, then multiply, scale and
// check, with at most 3*DIM_BITS halvings; a rounding takes D = ceil(DIM_BITS/4) remainder steps.
// One job at a time: a new job is taken only while the controller is idle.
// The next job is taken while a finished plan waits; a plan stalls until that one leaves.
// Reset: configuration returns to its defaults, controller idle, no plan pending.
`default_nettype none

module matmul_tile_size_planner
    import mtsp_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mtsp_in_if.sink                    i_in,
    mtsp_out_if.source                 o_out
);

    t_cfg r_cfg, n_cfg;
    t_cmd cmd;
    t_sts sts;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ARRAY_WIDTH:      n_cfg.array_width      = i_cfg_data[CW_W-1:0];
                CFG_ELEMENT_BYTES:    n_cfg.element_bytes    = i_cfg_data[EB_W-1:0];
                CFG_SCRATCHPAD_KIB:   n_cfg.scratchpad_kib   = i_cfg_data[SPK_W-1:0];
                CFG_TRANSPOSE_ENABLE: n_cfg.transpose_enable = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.array_width      <= RST_ARRAY_WIDTH;
            r_cfg.element_bytes    <= RST_ELEMENT_BYTES;
            r_cfg.scratchpad_kib   <= RST_SCRATCHPAD_KIB;
            r_cfg.transpose_enable <= RST_TRANSPOSE_ENABLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mtsp_ctrl #(
        .DIM_BITS (DIM_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mtsp_dp #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_cfg                (r_cfg),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_m_rows             (i_in.m_rows),
        .i_k_depth            (i_in.k_depth),
        .i_n_cols             (i_in.n_cols),
        .i_row_override_on    (i_in.row_override_on),
        .i_row_override_count (i_in.row_override_count),
        .o_tile_first         (o_out.tile_first),
        .o_tile_middle        (o_out.tile_middle),
        .o_tile_last          (o_out.tile_last),
        .o_count_first        (o_out.count_first),
        .o_count_middle       (o_out.count_middle),
        .o_count_last         (o_out.count_last),
        .o_transposed         (o_out.transposed),
        .o_k_major_order      (o_out.k_major_order),
        .o_fits               (o_out.fits)
    );

endmodule

`default_nettype wire
